### rtl/psp_pkg.sv
// ----------------------------------------------------------------------------
// psp_pkg
// Shared types and constants of the PSG register-dump stream parser.
// ----------------------------------------------------------------------------
package psp_pkg;

   // header length of a dump file in bytes
   localparam int HEADER_BYTES = 16;

   // position counter runs 0 .. HEADER_BYTES+1
   localparam int HDR_POS_W = $clog2(HEADER_BYTES + 2);
   localparam logic [HDR_POS_W-1:0] HDR_LAST = HDR_POS_W'(HEADER_BYTES);
   localparam logic [HDR_POS_W-1:0] HDR_BODY = HDR_POS_W'(HEADER_BYTES + 1);

   // command bytes
   localparam logic [7:0] CMD_LONG_PAUSE = 8'hFE;
   localparam logic [7:0] CMD_TICK       = 8'hFF;
   localparam logic [7:0] REG_COUNT      = 8'd16;

   // result kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_PAUSE = 1'b1;

   typedef enum logic [1:0] {
      MODE_CMD   = 2'd0,
      MODE_VALUE = 2'd1,
      MODE_PAUSE = 2'd2,
      MODE_SKIP  = 2'd3
   } psp_mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_file;
   } psp_req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  chip;
      logic [3:0]  reg_index;
      logic [7:0]  reg_value;
      logic [9:0]  pause_ticks;
      logic [31:0] total_ticks;
   } psp_rsp_type;

   typedef struct packed {
      logic [HDR_POS_W-1:0] hdr_pos;
      psp_mode_type         mode;
      logic [3:0]           pend_reg;
      logic [31:0]          ticks;
   } psp_state_type;

   typedef struct packed {
      logic        emit;
      psp_rsp_type rsp;
   } psp_step_type;

endpackage

### rtl/psp_stream_parser.sv
// ----------------------------------------------------------------------------
// psg_stream_parser
// Parses a PSG register dump byte stream into register writes and pauses.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  req_      in         req_valid / req_stall   psp_req_type (byte, file start)
//  rsp_      out        rsp_valid / rsp_stall   psp_rsp_type (write or pause)
//  csr_      in         csr_wr_en               csr_wr_data (chip number)
//
// one byte per cycle while req_stall is low; a result appears in the cycle
// after its byte is accepted. the parse step is a single combinational pass
// between the parser state registers and the result register.
// synchronous reset clears the parser state and chip number; no result valid.
// req_stall is high only while a held result is stalled downstream.
// ----------------------------------------------------------------------------
module psg_stream_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  psp_pkg::psp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output psp_pkg::psp_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data
);

   logic                   chip_id_ff;
   logic [7:0]             chip_ff;
   psp_pkg::psp_state_type state_ff, state_in;
   psp_pkg::psp_step_type  step;
   logic                   rsp_valid_ff, rsp_valid_in;
   psp_pkg::psp_rsp_type   rsp_data_ff, rsp_data_in;
   logic                   req_accept;
   logic                   rsp_free;

   // output register free when empty or being taken
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !rsp_free;
   assign req_accept = req_valid && rsp_free;

   // chip number register
   always_ff @(posedge clock) begin
      if (reset) begin
         chip_ff    <= '0;
         chip_id_ff <= 1'b0;
      end else if (csr_wr_en) begin
         chip_ff    <= csr_wr_data;
         chip_id_ff <= 1'b1;
      end
   end

   psp_decode u_decode (
      .cur_state  (state_ff),
      .req        (req_data),
      .chip_id    (chip_ff),
      .next_state (state_in),
      .step       (step)
   );

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.hdr_pos  <= '0;
         state_ff.mode     <= psp_pkg::MODE_CMD;
         state_ff.pend_reg <= '0;
         state_ff.ticks    <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // result register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in = step.emit;
         rsp_data_in  = step.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a file start byte is always a header byte and gives no result
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.first_of_file) |=> !rsp_valid_ff)
      else $error("result produced for a file start byte");

   // pause results carry a nonzero count and no register fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.kind == psp_pkg::KIND_PAUSE) |->
      (rsp_data_ff.pause_ticks != 10'd0 && rsp_data_ff.reg_index == 4'd0 &&
       rsp_data_ff.reg_value == 8'd0))
      else $error("malformed pause result");

   // tick total never decreases within a file
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_data.first_of_file) |=> (state_ff.ticks >= $past(state_ff.ticks)))
      else $error("tick total went backwards");

   // a written chip number shows on the next result word
   assert property (@(posedge clock) disable iff (reset)
      (chip_id_ff && rsp_valid_ff && req_accept && step.emit) |=>
      (rsp_data_ff.chip == $past(chip_ff)))
      else $error("result chip number mismatch");

   // parser state holds when no byte is accepted
   assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(state_ff))
      else $error("parser state changed without a byte");

endmodule

### rtl/psp_decode.sv
// ----------------------------------------------------------------------------
// psp_decode
// Per-byte parse step: next parser state and the optional result word.
// ----------------------------------------------------------------------------
module psp_decode (
   input  psp_pkg::psp_state_type cur_state,
   input  psp_pkg::psp_req_type   req,
   input  logic [7:0]             chip_id,
   output psp_pkg::psp_state_type next_state,
   output psp_pkg::psp_step_type  step
);

   psp_pkg::psp_state_type st;
   logic [7:0]  b;
   logic        add_en;
   logic [9:0]  add_ticks;
   logic [32:0] tick_sum;
   logic [31:0] tick_sat;
   logic        parse_en;

   assign b = req.data_byte;

   // restart clears the parser before the byte is handled
   always_comb begin
      if (req.first_of_file) begin
         st.hdr_pos  = '0;
         st.mode     = psp_pkg::MODE_CMD;
         st.pend_reg = '0;
         st.ticks    = '0;
      end else begin
         st = cur_state;
      end
   end

   // header skip and body parse
   always_comb begin
      next_state = st;
      parse_en   = 1'b0;
      add_en     = 1'b0;
      add_ticks  = '0;
      step.emit  = 1'b0;
      step.rsp.kind        = psp_pkg::KIND_WRITE;
      step.rsp.chip        = chip_id;
      step.rsp.reg_index   = '0;
      step.rsp.reg_value   = '0;
      step.rsp.pause_ticks = '0;
      step.rsp.total_ticks = st.ticks;

      if (st.hdr_pos < psp_pkg::HDR_LAST) begin
         next_state.hdr_pos = st.hdr_pos + 1'b1;
      end else if (st.hdr_pos == psp_pkg::HDR_LAST) begin
         next_state.hdr_pos = psp_pkg::HDR_BODY;
         parse_en = !(b == psp_pkg::CMD_LONG_PAUSE || b == psp_pkg::CMD_TICK);
      end else begin
         parse_en = 1'b1;
      end

      if (parse_en) begin
         unique case (st.mode)
            psp_pkg::MODE_VALUE: begin
               next_state.mode    = psp_pkg::MODE_CMD;
               step.emit          = 1'b1;
               step.rsp.reg_index = st.pend_reg;
               step.rsp.reg_value = b;
            end
            psp_pkg::MODE_PAUSE: begin
               next_state.mode = psp_pkg::MODE_CMD;
               if (b != 8'd0) begin
                  add_en    = 1'b1;
                  add_ticks = {b, 2'b00};
                  step.emit = 1'b1;
                  step.rsp.kind        = psp_pkg::KIND_PAUSE;
                  step.rsp.pause_ticks = add_ticks;
               end
            end
            psp_pkg::MODE_SKIP: begin
               next_state.mode = psp_pkg::MODE_CMD;
            end
            default: begin
               if (b == psp_pkg::CMD_TICK) begin
                  add_en    = 1'b1;
                  add_ticks = 10'd1;
                  step.emit = 1'b1;
                  step.rsp.kind        = psp_pkg::KIND_PAUSE;
                  step.rsp.pause_ticks = add_ticks;
               end else if (b == psp_pkg::CMD_LONG_PAUSE) begin
                  next_state.mode = psp_pkg::MODE_PAUSE;
               end else if (b < psp_pkg::REG_COUNT) begin
                  next_state.pend_reg = b[3:0];
                  next_state.mode     = psp_pkg::MODE_VALUE;
               end else begin
                  next_state.mode = psp_pkg::MODE_SKIP;
               end
            end
         endcase
      end

      // saturating tick total
      tick_sum = {1'b0, st.ticks} + {23'b0, add_ticks};
      tick_sat = tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];

      if (add_en) begin
         next_state.ticks     = tick_sat;
         step.rsp.total_ticks = tick_sat;
      end
   end

endmodule

### dv/tb_psg_stream_parser.sv
// ----------------------------------------------------------------------------
// tb_psg_stream_parser
// Self-checking bench for the PSG register-dump stream parser. A short table
// of bytes covers the header skip, the byte after the header, every command
// and the zero pause. Random dump files follow, mostly well formed, some cut
// short, some with a restart inside the header. The chip number changes
// between phases. Every accepted byte runs through a behavioral parser, and
// every accepted result word is compared field by field with the oldest
// predicted command. Both channels idle in random bursts, except in the
// last phase.
// ----------------------------------------------------------------------------
module tb_psg_stream_parser;

   timeunit 1ns;
   timeprecision 1ps;

   // one byte word as offered, with an optional typed-in expectation
   typedef struct packed {
      psp_pkg::psp_req_type word;
      logic                 typed;
      logic                 has_rsp;
      psp_pkg::psp_rsp_type rsp;
   } feed_row_type;

   localparam int DIR_ROWS = 29;

   // directed stimulus: header, byte after header, each command, zero pause
   localparam feed_row_type DIR_TABLE [0:DIR_ROWS-1] = '{
      '{'{8'h00, 1'b1}, 1'b0, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'h12, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'h34, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'hFE, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'h0F, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'h01, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'h80, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'h7F, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'h55, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'hAA, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'h10, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'h20, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'h40, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'h01, 1'b0}, 1'b0, 1'b0, '0},
      // tick byte right after the header is dropped
      '{'{8'hFF, 1'b0}, 1'b1, 1'b0, '0},
      '{'{8'h0F, 1'b0}, 1'b1, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b1, 1'b1,
        '{psp_pkg::KIND_WRITE, 8'h00, 4'hF, 8'hFF, 10'd0, 32'd0}},
      '{'{8'hFF, 1'b0}, 1'b1, 1'b1,
        '{psp_pkg::KIND_PAUSE, 8'h00, 4'h0, 8'h00, 10'd1, 32'd1}},
      '{'{8'hFE, 1'b0}, 1'b1, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b1, 1'b1,
        '{psp_pkg::KIND_PAUSE, 8'h00, 4'h0, 8'h00, 10'd1020, 32'd1021}},
      // long pause of zero gives nothing
      '{'{8'hFE, 1'b0}, 1'b1, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b1, 1'b0, '0},
      // unknown register swallows its value byte
      '{'{8'h10, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b1, 1'b0, '0},
      '{'{8'h80, 1'b0}, 1'b1, 1'b1,
        '{psp_pkg::KIND_WRITE, 8'h00, 4'h0, 8'h80, 10'd0, 32'd1021}},
      // file stops inside a long pause command
      '{'{8'hFE, 1'b0}, 1'b0, 1'b0, '0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   psp_pkg::psp_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   psp_pkg::psp_rsp_type rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [7:0]           csr_wr_data = 8'h00;

   feed_row_type         offer_row = '0;
   feed_row_type         word_q [$];
   psp_pkg::psp_rsp_type due_cmds [$];

   int idle_odds = 0;
   int stall_left = 0;
   int mismatch_count = 0;
   int queued_words = 0;

   // behavioral parser state
   logic [7:0]            chip_num;
   int                    hdr_seen;
   psp_pkg::psp_mode_type parse_mode;
   logic [3:0]            pend_reg;
   logic [31:0]           tick_sum;

   psg_stream_parser i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void clear_parse_state();
      hdr_seen   = 0;
      parse_mode = psp_pkg::MODE_CMD;
      pend_reg   = 4'h0;
      tick_sum   = 32'd0;
   endfunction

   // saturating add to the running tick total
   function automatic void add_ticks(input logic [9:0] n);
      logic [32:0] sum;
      sum = {1'b0, tick_sum} + 33'(n);
      tick_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   // one byte through the parser; returns 1 when it yields a command
   function automatic bit parse_byte(input psp_pkg::psp_req_type w,
                                     output psp_pkg::psp_rsp_type r);
      logic [9:0] ticks;
      r = '0;
      r.chip = chip_num;
      if (w.first_of_file) begin
         clear_parse_state();
      end
      if (hdr_seen < psp_pkg::HEADER_BYTES) begin
         hdr_seen++;
         return 1'b0;
      end
      if (hdr_seen == psp_pkg::HEADER_BYTES) begin
         hdr_seen = psp_pkg::HEADER_BYTES + 1;
         if (w.data_byte == psp_pkg::CMD_LONG_PAUSE || w.data_byte == psp_pkg::CMD_TICK) begin
            return 1'b0;
         end
      end
      case (parse_mode)
         psp_pkg::MODE_VALUE: begin
            parse_mode = psp_pkg::MODE_CMD;
            r.kind = psp_pkg::KIND_WRITE;
            r.reg_index = pend_reg;
            r.reg_value = w.data_byte;
            r.total_ticks = tick_sum;
            return 1'b1;
         end
         psp_pkg::MODE_PAUSE: begin
            parse_mode = psp_pkg::MODE_CMD;
            if (w.data_byte == 8'h00) begin
               return 1'b0;
            end
            ticks = {w.data_byte, 2'b00};
            add_ticks(ticks);
            r.kind = psp_pkg::KIND_PAUSE;
            r.pause_ticks = ticks;
            r.total_ticks = tick_sum;
            return 1'b1;
         end
         psp_pkg::MODE_SKIP: begin
            parse_mode = psp_pkg::MODE_CMD;
            return 1'b0;
         end
         default: ;
      endcase
      if (w.data_byte == psp_pkg::CMD_TICK) begin
         add_ticks(10'd1);
         r.kind = psp_pkg::KIND_PAUSE;
         r.pause_ticks = 10'd1;
         r.total_ticks = tick_sum;
         return 1'b1;
      end
      if (w.data_byte == psp_pkg::CMD_LONG_PAUSE) begin
         parse_mode = psp_pkg::MODE_PAUSE;
      end else if (w.data_byte < psp_pkg::REG_COUNT) begin
         pend_reg = w.data_byte[3:0];
         parse_mode = psp_pkg::MODE_VALUE;
      end else begin
         parse_mode = psp_pkg::MODE_SKIP;
      end
      return 1'b0;
   endfunction

   // monitor: check result words, then predict from the accepted byte word
   always @(posedge clock) begin
      psp_pkg::psp_rsp_type exp_cmd;
      psp_pkg::psp_rsp_type got;
      bit                   has;
      if (reset) begin
         chip_num = 8'h00;
         clear_parse_state();
      end else begin
         if (csr_wr_en) begin
            chip_num = csr_wr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (due_cmds.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, got);
               mismatch_count++;
            end else begin
               exp_cmd = due_cmds.pop_front();
               if (got.kind !== exp_cmd.kind) begin
                  $display("%0t: kind expected %h got %h", $time, exp_cmd.kind, got.kind);
                  mismatch_count++;
               end
               if (got.chip !== exp_cmd.chip) begin
                  $display("%0t: chip expected %h got %h", $time, exp_cmd.chip, got.chip);
                  mismatch_count++;
               end
               if (got.reg_index !== exp_cmd.reg_index) begin
                  $display("%0t: reg_index expected %h got %h", $time,
                           exp_cmd.reg_index, got.reg_index);
                  mismatch_count++;
               end
               if (got.reg_value !== exp_cmd.reg_value) begin
                  $display("%0t: reg_value expected %h got %h", $time,
                           exp_cmd.reg_value, got.reg_value);
                  mismatch_count++;
               end
               if (got.pause_ticks !== exp_cmd.pause_ticks) begin
                  $display("%0t: pause_ticks expected %0d got %0d", $time,
                           exp_cmd.pause_ticks, got.pause_ticks);
                  mismatch_count++;
               end
               if (got.total_ticks !== exp_cmd.total_ticks) begin
                  $display("%0t: total_ticks expected %0d got %0d", $time,
                           exp_cmd.total_ticks, got.total_ticks);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            has = parse_byte(req_data, exp_cmd);
            if (offer_row.typed) begin
               has = offer_row.has_rsp;
               exp_cmd = offer_row.rsp;
            end
            if (has) begin
               due_cmds.push_back(exp_cmd);
            end
         end
      end
   end

   // downstream stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_odds) begin
         stall_left <= $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic queue_word(input logic [7:0] b, input logic first);
      feed_row_type row;
      row = '0;
      row.word.data_byte = b;
      row.word.first_of_file = first;
      word_q.push_back(row);
      queued_words++;
   endtask

   // one random dump file, mostly well formed
   task automatic queue_file();
      int hdr_len;
      int n_cmds;
      hdr_len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, psp_pkg::HEADER_BYTES - 1)
                                             : psp_pkg::HEADER_BYTES;
      for (int i = 0; i < hdr_len; i++) begin
         queue_word(8'($urandom_range(0, 255)), i == 0);
      end
      if (hdr_len < psp_pkg::HEADER_BYTES) begin
         return;
      end
      // byte right after the header
      case ($urandom_range(0, 3))
         0: queue_word(psp_pkg::CMD_LONG_PAUSE, 1'b0);
         1: queue_word(psp_pkg::CMD_TICK, 1'b0);
         default: ;
      endcase
      n_cmds = $urandom_range(4, 40);
      for (int i = 0; i < n_cmds; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               queue_word(8'($urandom_range(0, 15)), 1'b0);
               queue_word(8'($urandom_range(0, 255)), 1'b0);
            end
            4, 5: queue_word(psp_pkg::CMD_TICK, 1'b0);
            6, 7: begin
               queue_word(psp_pkg::CMD_LONG_PAUSE, 1'b0);
               queue_word(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
                          1'b0);
            end
            8: begin
               queue_word(8'($urandom_range(16, 253)), 1'b0);
               queue_word(8'($urandom_range(0, 255)), 1'b0);
            end
            default: queue_word(8'($urandom_range(0, 255)), 1'b0);
         endcase
      end
      // some files stop in the middle of a command
      case ($urandom_range(0, 5))
         0: queue_word(psp_pkg::CMD_LONG_PAUSE, 1'b0);
         1: queue_word(8'($urandom_range(0, 15)), 1'b0);
         2: queue_word(8'($urandom_range(16, 253)), 1'b0);
         default: ;
      endcase
   endtask

   // offer queued byte words, with random gaps between them
   task automatic feed_words();
      int gap;
      gap = 0;
      while (word_q.size() > 0) begin
         if (gap == 0 && $urandom_range(0, 99) < idle_odds) begin
            gap = $urandom_range(1, 15);
         end
         if (gap > 0) begin
            gap--;
            req_valid <= 1'b0;
            @(posedge clock);
         end else begin
            req_valid <= 1'b1;
            req_data <= word_q[0].word;
            offer_row <= word_q[0];
            @(posedge clock);
            while (req_stall) begin
               @(posedge clock);
            end
            void'(word_q.pop_front());
         end
      end
   endtask

   // stop offering bytes and wait until every predicted command is out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_cmds.size() > 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_chip(input logic [7:0] v);
      csr_wr_data <= v;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [7:0] chip_plan [4];
      int         phase_odds [4];
      int         phase_goal;
      chip_plan = '{8'hFF, 8'($urandom_range(1, 254)), 8'h00, 8'($urandom_range(1, 254))};
      phase_odds = '{15, 6, 30, 0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table with the reset chip number
      idle_odds = 15;
      for (int i = 0; i < DIR_ROWS; i++) begin
         word_q.push_back(DIR_TABLE[i]);
      end
      feed_words();
      drain();

      // random files, one chip number per phase
      for (int p = 0; p < 4; p++) begin
         write_chip(chip_plan[p]);
         phase_goal = queued_words + 330;
         while (queued_words < phase_goal) begin
            idle_odds = ($urandom_range(0, 3) == 0) ? 0 : phase_odds[p];
            queue_file();
            feed_words();
         end
         drain();
      end

      if (mismatch_count == 0 && due_cmds.size() == 0) begin
         $display("PASS psg_stream_parser");
      end else begin
         $display("FAIL psg_stream_parser");
      end
      $finish;
   end

   // run limit
   initial begin
      #(20_000_000);
      $display("FAIL psg_stream_parser");
      $finish;
   end

endmodule
